FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the charset detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: sv/jcd_pkg.sv
// Types and constants of the Japanese charset detector.
`timescale 1ns / 1ps
package jcd_pkg;

  localparam int BYTE_W  = 8;
  localparam int SCORE_W = 13;
  localparam int PEND_W  = 3;

  // Result codes of the charset decision
  typedef enum logic [1:0] {
    CS_NONE = 2'd0,
    CS_SJIS = 2'd1,
    CS_EUC  = 2'd2,
    CS_UTF8 = 2'd3
  } jcd_charset_t;

  // Per-decoder mode flags carried from byte to byte
  typedef struct packed {
    logic              sjis_lead;
    logic              euc_lead;
    logic [PEND_W-1:0] utf8_pending;
    logic              utf8_failed;
  } jcd_flags_t;

  // Score events raised by one byte
  typedef struct packed {
    logic sjis_hit;
    logic euc_hit;
    logic utf8_hit;
    logic utf8_err;
  } jcd_event_t;

  localparam jcd_flags_t FLAGS_RESET = '{
    sjis_lead:    1'b0,
    euc_lead:     1'b0,
    utf8_pending: '0,
    utf8_failed:  1'b0
  };

endpackage

FILE: sv/japanese_charset_detector.sv
// Usage notes:
// Input channel: data_byte with last_byte, under in_valid / in_stall. Set
// last_byte on the final byte of a buffer. Output channel: charset_id, the
// three scores and utf8_invalid, under out_valid / out_stall; exactly one
// result item comes out for each buffer, on its final byte only.
// An accepted byte goes into the input register and is scored from there;
// a final byte's result item goes into the result register and out_valid.
// Throughput is one byte per cycle while no final byte is held by in_stall;
// the limit is the single scoring stage between the two registers.
// Scores saturate at MAX_BYTES and are reported in their low 13 bits.
// After a final byte all scores and modes go back to zero for the next buffer.
// Reset (rst, synchronous) clears the scores, the modes and both valid flags.
// While the receiver stalls and a result item waits, bytes that are not final
// keep flowing; a final byte waits in the input register and in_stall rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module japanese_charset_detector #(
  parameter int MAX_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jcd_pkg::BYTE_W-1:0]    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    charset_id,
  output logic [jcd_pkg::SCORE_W-1:0]   sjis_score,
  output logic [jcd_pkg::SCORE_W-1:0]   euc_score,
  output logic [jcd_pkg::SCORE_W-1:0]   utf8_score,
  output logic                          utf8_invalid
);

  localparam int CNT_W   = $clog2(MAX_BYTES + 1);
  localparam int SCORE_W = jcd_pkg::SCORE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);

  // Input register
  logic                       s1_valid;
  logic [jcd_pkg::BYTE_W-1:0] s1_byte;
  logic                       s1_last;
  logic                       s1_adv;
  logic                       s1_fire;

  // Scoring state
  jcd_pkg::jcd_flags_t flags;
  jcd_pkg::jcd_flags_t flags_next;
  jcd_pkg::jcd_event_t ev;
  logic [CNT_W-1:0]    sjis_count, sjis_count_next;
  logic [CNT_W-1:0]    euc_count, euc_count_next;
  logic [CNT_W-1:0]    utf8_count, utf8_count_next;
  jcd_pkg::jcd_charset_t charset_next;

  // A final byte needs a free result slot; other bytes always advance
  assign s1_adv   = !s1_last || !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  jcd_step u_step (
    .data_byte  (s1_byte),
    .flags      (flags),
    .flags_next (flags_next),
    .ev         (ev)
  );

  // Saturating score updates
  always_comb begin
    sjis_count_next = sjis_count;
    euc_count_next  = euc_count;
    utf8_count_next = utf8_count;
    if (ev.sjis_hit && sjis_count < CNT_MAX) begin
      sjis_count_next = sjis_count + 1'b1;
    end
    if (ev.euc_hit && euc_count < CNT_MAX) begin
      euc_count_next = euc_count + 1'b1;
    end
    if (ev.utf8_hit && utf8_count < CNT_MAX) begin
      utf8_count_next = utf8_count + 1'b1;
    end else if (ev.utf8_err && utf8_count != '0) begin
      utf8_count_next = utf8_count - 1'b1;
    end
  end

  // Pick the charset with the strictly highest score; a tie, or a failed UTF-8 on top, gives CS_NONE
  always_comb begin
    if (euc_count_next > sjis_count_next && euc_count_next > utf8_count_next) begin
      charset_next = jcd_pkg::CS_EUC;
    end else if (!flags_next.utf8_failed && utf8_count_next > euc_count_next &&
                 utf8_count_next > sjis_count_next) begin
      charset_next = jcd_pkg::CS_UTF8;
    end else if (sjis_count_next > euc_count_next &&
                 sjis_count_next > utf8_count_next) begin
      charset_next = jcd_pkg::CS_SJIS;
    end else begin
      charset_next = jcd_pkg::CS_NONE;
    end
  end

  // Advance the scoring state; drop back to reset after a final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= jcd_pkg::FLAGS_RESET;
      sjis_count <= '0;
      euc_count  <= '0;
      utf8_count <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        flags      <= jcd_pkg::FLAGS_RESET;
        sjis_count <= '0;
        euc_count  <= '0;
        utf8_count <= '0;
      end else begin
        flags      <= flags_next;
        sjis_count <= sjis_count_next;
        euc_count  <= euc_count_next;
        utf8_count <= utf8_count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      charset_id   <= charset_next;
      sjis_score   <= SCORE_W'(sjis_count_next);
      euc_score    <= SCORE_W'(euc_count_next);
      utf8_score   <= SCORE_W'(utf8_count_next);
      utf8_invalid <= flags_next.utf8_failed;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst, sjis_count <= CNT_MAX && euc_count <= CNT_MAX && utf8_count <= CNT_MAX, "score above saturation limit")
  `ASSERT_CLK(a_pend_range, clk, rst, flags.utf8_pending <= 3'd5, "UTF-8 pending count out of range")
  `ASSERT_CLK(a_clear_after_last, clk, rst, (s1_fire && s1_last) |=> (sjis_count == '0 && euc_count == '0 && utf8_count == '0 && !flags.utf8_failed), "state not cleared after final item")
  `ASSERT_CLK(a_utf8_frozen, clk, rst, (flags.utf8_failed && !(s1_fire && s1_last)) |=> $stable(utf8_count), "UTF-8 score moved after failure")

endmodule

FILE: sv/jcd_step.sv
// Per-byte decoder: next mode flags and score events for one byte.
`timescale 1ns / 1ps
module jcd_step (
  input  logic [jcd_pkg::BYTE_W-1:0] data_byte,
  input  jcd_pkg::jcd_flags_t        flags,
  output jcd_pkg::jcd_flags_t        flags_next,
  output jcd_pkg::jcd_event_t        ev
);

  logic sjis_lead_byte;
  logic sjis_trail_byte;
  logic euc_byte;
  logic utf8_cont;

  // Classify the byte
  assign sjis_lead_byte  = (data_byte >= 8'h81 && data_byte <= 8'h9f) ||
                           (data_byte >= 8'he0 && data_byte <= 8'hf0);
  assign sjis_trail_byte = (data_byte >= 8'h40 && data_byte <= 8'h7e) ||
                           (data_byte >= 8'h80 && data_byte <= 8'hfc);
  assign euc_byte        = (data_byte >= 8'ha1 && data_byte <= 8'hfe);
  assign utf8_cont       = (data_byte[7:6] == 2'b10);

  always_comb begin
    flags_next = flags;
    ev         = '0;

    // Shift_JIS: score a trail byte after a lead, else look for a lead
    if (flags.sjis_lead) begin
      ev.sjis_hit          = sjis_trail_byte;
      flags_next.sjis_lead = 1'b0;
    end else begin
      flags_next.sjis_lead = sjis_lead_byte;
    end

    // EUC-JP: score a second high byte after a first one
    if (flags.euc_lead) begin
      ev.euc_hit          = euc_byte;
      flags_next.euc_lead = 1'b0;
    end else begin
      flags_next.euc_lead = euc_byte;
    end

    // UTF-8: freeze the UTF-8 state once failed
    if (!flags.utf8_failed) begin
      if (flags.utf8_pending == '0) begin
        if (data_byte[7]) begin
          casez (data_byte)
            8'b110?_????: flags_next.utf8_pending = 3'd1;
            8'b1110_????: flags_next.utf8_pending = 3'd2;
            8'b1111_0???: flags_next.utf8_pending = 3'd3;
            8'b1111_10??: flags_next.utf8_pending = 3'd4;
            8'b1111_110?: flags_next.utf8_pending = 3'd5;
            default: begin
              ev.utf8_err            = 1'b1;
              flags_next.utf8_failed = 1'b1;
            end
          endcase
        end
      end else if (utf8_cont) begin
        ev.utf8_hit             = 1'b1;
        flags_next.utf8_pending = flags.utf8_pending - 3'd1;
      end else begin
        ev.utf8_err             = 1'b1;
        flags_next.utf8_pending = '0;
        flags_next.utf8_failed  = 1'b1;
      end
    end
  end

endmodule
